// ----- src/lwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line window clipper package
// Shared constants and types for the segment clipping pipeline.
// ----------------------------------------------------------------------------
package lwc_pkg;

  localparam int DIM_BITS  = 14;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 14'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic vert;
    logic horiz;
  } seg_kind_t;

endpackage

// ----- src/lwc_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment preparation
// Orders the endpoints, forms the divider operands and their products.
// ----------------------------------------------------------------------------
module lwc_prep import lwc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [DIM_BITS-1:0]          width,
  input  logic [DIM_BITS-1:0]          height,
  output seg_kind_t                    kind_o,
  output logic signed [COORD_BITS-1:0] x1_o,
  output logic signed [COORD_BITS-1:0] y1_o,
  output logic signed [COORD_BITS-1:0] x2_o,
  output logic signed [COORD_BITS-1:0] y2_o,
  output logic [2*(((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1)-1:0]
                                       prod_o [4],
  output logic [((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1):0] dvs_o [4],
  output logic signed [COORD_BITS-1:0] base_o [4],
  output logic                         neg_o  [4]
);

  localparam int MW = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int PW = 2 * MW;
  localparam int SW = MW + 1;

  logic                         vert, horiz;
  logic signed [COORD_BITS-1:0] ox1, oy1, ox2, oy2;
  logic signed [SW-1:0]         dx, dy, wm1, hm1;
  logic signed [SW-1:0]         tv [4];
  logic signed [SW-1:0]         pv [4];
  logic signed [SW-1:0]         qv [4];
  logic signed [COORD_BITS-1:0] bv [4];

  seg_kind_t                    kind1;
  logic signed [COORD_BITS-1:0] x1a, y1a, x2a, y2a;
  logic [MW-1:0]                ma [4];
  logic [MW-1:0]                mb [4];
  logic [MW-1:0]                md [4];
  logic signed [COORD_BITS-1:0] bs [4];
  logic                         ng [4];

  always_comb begin
    vert  = (start_x == end_x);
    horiz = !vert && (start_y == end_y);
    ox1 = start_x;
    oy1 = start_y;
    ox2 = end_x;
    oy2 = end_y;
    if (vert) begin
      if (start_y > end_y) begin
        oy1 = end_y;
        oy2 = start_y;
      end
    end else if (horiz) begin
      if (start_x > end_x) begin
        ox1 = end_x;
        ox2 = start_x;
      end
    end else if (start_x > end_x) begin
      ox1 = end_x;
      oy1 = end_y;
      ox2 = start_x;
      oy2 = start_y;
    end
    dx  = SW'(ox2) - SW'(ox1);
    dy  = SW'(oy2) - SW'(oy1);
    wm1 = $signed({{(SW-DIM_BITS){1'b0}}, width}) - SW'(1);
    hm1 = $signed({{(SW-DIM_BITS){1'b0}}, height}) - SW'(1);
    // y at x = 0, y at x = width-1, x at y = 0, x at y = height-1
    tv[0] = -SW'(ox1);
    tv[1] = wm1 - SW'(ox1);
    tv[2] = -SW'(oy1);
    tv[3] = hm1 - SW'(oy1);
    pv[0] = dy;  pv[1] = dy;  pv[2] = dx;  pv[3] = dx;
    qv[0] = dx;  qv[1] = dx;  qv[2] = dy;  qv[3] = dy;
    bv[0] = oy1; bv[1] = oy1; bv[2] = ox1; bv[3] = ox1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= '{vert: vert, horiz: horiz};
      x1a <= ox1;
      y1a <= oy1;
      x2a <= ox2;
      y2a <= oy2;
      for (int u = 0; u < 4; u++) begin
        ma[u] <= pv[u][SW-1] ? MW'(-pv[u]) : MW'(pv[u]);
        mb[u] <= tv[u][SW-1] ? MW'(-tv[u]) : MW'(tv[u]);
        md[u] <= qv[u][SW-1] ? MW'(-qv[u]) : MW'(qv[u]);
        bs[u] <= bv[u];
        ng[u] <= pv[u][SW-1] ^ tv[u][SW-1] ^ qv[u][SW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_o <= kind1;
      x1_o <= x1a;
      y1_o <= y1a;
      x2_o <= x2a;
      y2_o <= y2a;
      for (int u = 0; u < 4; u++) begin
        prod_o[u] <= PW'(ma[u]) * PW'(mb[u]);
        dvs_o[u]  <= md[u];
        base_o[u] <= bs[u];
        neg_o[u]  <= ng[u];
      end
    end
  end

endmodule

// ----- src/lwc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined point-on-line divider
// One quotient bit per stage, then truncation toward zero around the base.
// ----------------------------------------------------------------------------
module lwc_div import lwc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [2*(((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1)-1:0] prod,
  input  logic [((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1):0]          dvs,
  input  logic signed [COORD_BITS-1:0] base,
  input  logic                         neg,
  output logic signed [2*(((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1)+1:0]
                                       res
);

  localparam int MW = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int PW = 2 * MW;
  localparam int RW = PW + 2;

  logic [MW-1:0]                rem [1:PW];
  logic [PW-1:0]                dnd [1:PW];
  logic [PW-1:0]                quo [1:PW];
  logic [MW-1:0]                dv  [1:PW];
  logic signed [COORD_BITS-1:0] bs  [1:PW];
  logic                         ng  [1:PW];

  genvar k;
  generate
    for (k = 1; k <= PW; k++) begin : g_stage
      logic [MW-1:0]                rem_in, dv_in;
      logic [PW-1:0]                dnd_in, quo_in;
      logic signed [COORD_BITS-1:0] bs_in;
      logic                         ng_in, ge;
      logic [MW:0]                  trial;
      if (k == 1) begin : g_first
        assign rem_in = '0;
        assign dnd_in = prod;
        assign quo_in = '0;
        assign dv_in  = dvs;
        assign bs_in  = base;
        assign ng_in  = neg;
      end else begin : g_next
        assign rem_in = rem[k-1];
        assign dnd_in = dnd[k-1];
        assign quo_in = quo[k-1];
        assign dv_in  = dv[k-1];
        assign bs_in  = bs[k-1];
        assign ng_in  = ng[k-1];
      end
      assign trial = {rem_in, dnd_in[PW-1]};
      assign ge    = (trial >= {1'b0, dv_in});
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k] <= ge ? MW'(trial - {1'b0, dv_in}) : trial[MW-1:0];
          dnd[k] <= {dnd_in[PW-2:0], 1'b0};
          quo[k] <= {quo_in[PW-2:0], ge};
          dv[k]  <= dv_in;
          bs[k]  <= bs_in;
          ng[k]  <= ng_in;
        end
      end
    end
  endgenerate

  logic                 rnz;
  logic signed [RW-1:0] qx, fv, sm;

  always_comb begin
    rnz = |rem[PW];
    qx  = $signed({2'b00, quo[PW]});
    fv  = ng[PW] ? (-qx - RW'(rnz)) : qx;
    sm  = RW'(bs[PW]) + fv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= (sm < 0 && rnz) ? sm + RW'(1) : sm;
    end
  end

endmodule

// ----- src/lwc_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip selection
// Picks the clipped endpoints, then handles vertical and horizontal segments.
// ----------------------------------------------------------------------------
module lwc_select import lwc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  seg_kind_t                    kind,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  input  logic [DIM_BITS-1:0]          width,
  input  logic [DIM_BITS-1:0]          height,
  input  logic signed [2*(((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1)+1:0]
                                       res [4],
  output logic                         out_valid,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] clip_start_x,
  output logic signed [COORD_BITS-1:0] clip_start_y,
  output logic signed [COORD_BITS-1:0] clip_end_x,
  output logic signed [COORD_BITS-1:0] clip_end_y
);

  localparam int MW = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int RW = 2 * MW + 2;

  logic signed [RW-1:0] ww, hh, wm1, hm1;
  logic signed [RW-1:0] gx1, gy1, gx2, gy2;
  logic                 grej;
  seg_kind_t            gkind;

  logic                 a_valid, a_rej;
  seg_kind_t            a_kind;
  logic signed [RW-1:0] ax1, ay1, ax2, ay2;

  logic signed [RW-1:0] bx1, by1, bx2, by2, sw;
  logic                 bvis;

  always_comb begin
    ww  = $signed({{(RW-DIM_BITS){1'b0}}, width});
    hh  = $signed({{(RW-DIM_BITS){1'b0}}, height});
    wm1 = ww - RW'(1);
    hm1 = hh - RW'(1);
    gx1 = RW'(x1);
    gy1 = RW'(y1);
    gx2 = RW'(x2);
    gy2 = RW'(y2);
    grej  = 1'b0;
    gkind = kind;
    if (!kind.vert && !kind.horiz) begin
      if (gx1 < 0) begin
        gx1 = '0;
        gy1 = res[0];
      end
      grej = (gx1 >= ww) || (gx2 < 0);
      if (gx2 > wm1) begin
        gx2 = wm1;
        gy2 = res[1];
      end
      grej = grej || (gy1 < 0 && gy2 < 0) || (gy1 >= hh && gy2 >= hh);
      if (gy1 < 0) begin
        gy1 = '0;
        gx1 = res[2];
      end
      if (gy1 >= hh) begin
        gy1 = hm1;
        gx1 = res[3];
      end
      if (gy2 < 0) begin
        gy2 = '0;
        gx2 = res[2];
      end
      if (gy2 >= hh) begin
        gy2 = hm1;
        gx2 = res[3];
      end
      gkind.vert  = (gx1 == gx2);
      gkind.horiz = (gx1 != gx2) && (gy1 == gy2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rej  <= grej;
      a_kind <= gkind;
      ax1 <= gx1;
      ay1 <= gy1;
      ax2 <= gx2;
      ay2 <= gy2;
    end
  end

  always_comb begin
    bx1  = ax1;
    by1  = ay1;
    bx2  = ax2;
    by2  = ay2;
    bvis = !a_rej;
    sw   = '0;
    if (a_kind.vert) begin
      if (by1 > by2) begin
        sw  = by1;
        by1 = by2;
        by2 = sw;
      end
      if (bx1 < 0 || bx1 >= ww) bvis = 1'b0;
      if (by1 < 0) by1 = '0;
      if (by2 >= hh) by2 = hh;
    end else if (a_kind.horiz) begin
      if (bx1 > bx2) begin
        sw  = bx1;
        bx1 = bx2;
        bx2 = sw;
      end
      if (by1 < 0 || by1 >= hh) bvis = 1'b0;
      if (bx1 < 0) bx1 = '0;
      if (bx2 > ww) bx2 = ww;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visible      <= bvis;
      clip_start_x <= bvis ? bx1[COORD_BITS-1:0] : '0;
      clip_start_y <= bvis ? by1[COORD_BITS-1:0] : '0;
      clip_end_x   <= bvis ? bx2[COORD_BITS-1:0] : '0;
      clip_end_y   <= bvis ? by2[COORD_BITS-1:0] : '0;
    end
  end

endmodule

// ----- src/line_window_clipper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line window clipper
// Clips one segment per request against a 0..width by 0..height window.
// ----------------------------------------------------------------------------
// Input stream s_*: one segment per request (start_x, start_y, end_x, end_y).
// Output stream m_*: visible flag in m_tuser and the clipped endpoints in
// m_tdata; all endpoints are zero when the segment is rejected.
// The APB port holds the window width (0x0) and height (0x4); write them
// only while no request is in flight.
// The pipeline depth is set by the restoring divider that produces one
// quotient bit per stage, and throughput is one request per cycle when no
// output stall holds the pipeline: four dividers run side by side.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads width 640 and height 480.
// ----------------------------------------------------------------------------
module line_window_clipper_core import lwc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // visible
  output logic                           m_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ADDR_BITS-1:0]           paddr,
  input  logic [DATA_BITS-1:0]           pwdata,
  output logic [DATA_BITS-1:0]           prdata,
  output logic                           pready
);

  localparam int MW  = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int PW  = 2 * MW;
  localparam int RW  = PW + 2;
  localparam int TW  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int LAT = PW + 1;
  localparam int VL  = LAT + 2;

  typedef struct packed {
    seg_kind_t                    kind;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
  } side_t;

  logic [DIM_BITS-1:0] width, height;
  logic                adv;
  logic [VL-1:0]       vld;

  seg_kind_t                    p_kind;
  logic signed [COORD_BITS-1:0] p_x1, p_y1, p_x2, p_y2;
  logic [PW-1:0]                p_prod [4];
  logic [MW-1:0]                p_dvs  [4];
  logic signed [COORD_BITS-1:0] p_base [4];
  logic                         p_neg  [4];
  logic signed [RW-1:0]         d_res  [4];
  side_t                        side [0:LAT-1];

  logic                         o_vis;
  logic signed [COORD_BITS-1:0] o_sx, o_sy, o_ex, o_ey;

  assign pready   = 1'b1;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WIDTH_RESET;
      height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel_t'(paddr[2]))
        REG_WIDTH:  width  <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT: height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel_t'(paddr[2]))
      REG_WIDTH:  prdata = {{(DATA_BITS-DIM_BITS){1'b0}}, width};
      REG_HEIGHT: prdata = {{(DATA_BITS-DIM_BITS){1'b0}}, height};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VL-2:0], s_tvalid};
    end
  end

  lwc_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk     (clk),
    .adv     (adv),
    .start_x ($signed(s_tdata[COORD_BITS-1:0])),
    .start_y ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
    .end_x   ($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .end_y   ($signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .width   (width),
    .height  (height),
    .kind_o  (p_kind),
    .x1_o    (p_x1),
    .y1_o    (p_y1),
    .x2_o    (p_x2),
    .y2_o    (p_y2),
    .prod_o  (p_prod),
    .dvs_o   (p_dvs),
    .base_o  (p_base),
    .neg_o   (p_neg)
  );

  genvar u;
  generate
    for (u = 0; u < 4; u++) begin : g_div
      lwc_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk  (clk),
        .adv  (adv),
        .prod (p_prod[u]),
        .dvs  (p_dvs[u]),
        .base (p_base[u]),
        .neg  (p_neg[u]),
        .res  (d_res[u])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{kind: p_kind, x1: p_x1, y1: p_y1, x2: p_x2, y2: p_y2};
      for (int i = 1; i < LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  lwc_select #(.COORD_BITS(COORD_BITS)) u_select (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (vld[VL-1]),
    .kind         (side[LAT-1].kind),
    .x1           (side[LAT-1].x1),
    .y1           (side[LAT-1].y1),
    .x2           (side[LAT-1].x2),
    .y2           (side[LAT-1].y2),
    .width        (width),
    .height       (height),
    .res          (d_res),
    .out_valid    (m_tvalid),
    .visible      (o_vis),
    .clip_start_x (o_sx),
    .clip_start_y (o_sy),
    .clip_end_x   (o_ex),
    .clip_end_y   (o_ey)
  );

  assign m_tuser = o_vis;
  assign m_tdata = TW'({o_ey, o_ex, o_sy, o_sx});

  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid set after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected segment carries nonzero endpoints");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line window clipper testbench
// Drives segments into the clipper through the input stream and checks each
// clipped result against an in-bench clipping predictor. It runs a directed
// table first, then random segments under several window sizes. Both stream
// sides idle at random, with one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import lwc_pkg::*;

  localparam int CB = 16;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 60;

  typedef struct packed {
    bit              visible;
    logic [CB-1:0]   sx, sy, ex, ey;
  } clip_t;

  typedef struct {
    shortint sx, sy, ex, ey;
    bit      known;
    clip_t   want;
  } seg_row_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [63:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0, prdata;

  line_window_clipper_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  longint win_w = 640, win_h = 480;
  clip_t  pending_clips[$];
  int     errors = 0;
  int     cycles = 0;
  bit     calm = 0;
  int     stall_left = 0;

  // exact point on the original line, truncated toward zero
  function automatic longint on_line(longint p0, longint q0, longint dp, longint dq,
                                     longint v);
    return (p0 * dq + dp * (v - q0)) / dq;
  endfunction

  function automatic bit clip_vert(inout longint x1, inout longint y1,
                                   inout longint x2, inout longint y2);
    longint s;
    if (y1 > y2) begin
      s = y1; y1 = y2; y2 = s;
    end
    if (x1 < 0 || x1 >= win_w) return 0;
    if (y1 < 0) y1 = 0;
    if (y2 >= win_h) y2 = win_h;
    return 1;
  endfunction

  function automatic bit clip_horiz(inout longint x1, inout longint y1,
                                    inout longint x2, inout longint y2);
    longint s;
    if (x1 > x2) begin
      s = x1; x1 = x2; x2 = s;
    end
    if (y1 < 0 || y1 >= win_h) return 0;
    if (x1 < 0) x1 = 0;
    if (x2 > win_w) x2 = win_w;
    return 1;
  endfunction

  function automatic clip_t clip_segment(shortint a, shortint b, shortint c, shortint d);
    longint x1 = a, y1 = b, x2 = c, y2 = d, ox, oy, dx, dy, s;
    bit ok;
    clip_t r;
    if (x1 == x2) ok = clip_vert(x1, y1, x2, y2);
    else if (y1 == y2) ok = clip_horiz(x1, y1, x2, y2);
    else begin
      if (x1 > x2) begin
        s = x1; x1 = x2; x2 = s;
        s = y1; y1 = y2; y2 = s;
      end
      ox = x1; oy = y1; dx = x2 - x1; dy = y2 - y1;
      ok = 1;
      if (x1 < 0) begin
        x1 = 0; y1 = on_line(oy, ox, dy, dx, 0);
      end
      if (x1 >= win_w || x2 < 0) ok = 0;
      else begin
        if (x2 > win_w - 1) begin
          x2 = win_w - 1; y2 = on_line(oy, ox, dy, dx, win_w - 1);
        end
        if ((y1 < 0 && y2 < 0) || (y1 >= win_h && y2 >= win_h)) ok = 0;
        else begin
          if (y1 < 0) begin
            y1 = 0; x1 = on_line(ox, oy, dx, dy, 0);
          end
          if (y1 >= win_h) begin
            y1 = win_h - 1; x1 = on_line(ox, oy, dx, dy, win_h - 1);
          end
          if (y2 < 0) begin
            y2 = 0; x2 = on_line(ox, oy, dx, dy, 0);
          end
          if (y2 >= win_h) begin
            y2 = win_h - 1; x2 = on_line(ox, oy, dx, dy, win_h - 1);
          end
          if (x1 == x2) ok = clip_vert(x1, y1, x2, y2);
          else if (y1 == y2) ok = clip_horiz(x1, y1, x2, y2);
        end
      end
    end
    r.visible = ok;
    r.sx = ok ? x1[CB-1:0] : '0;
    r.sy = ok ? y1[CB-1:0] : '0;
    r.ex = ok ? x2[CB-1:0] : '0;
    r.ey = ok ? y2[CB-1:0] : '0;
    return r;
  endfunction

  task automatic send_segment(shortint a, shortint b, shortint c, shortint d,
                              bit known, clip_t want);
    clip_t p;
    while (!calm && $urandom_range(99) < 30) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {d, c, b, a};
    do @(posedge clk); while (!s_tready);
    p = clip_segment(a, b, c, d);
    if (known && p != want) begin
      errors++;
      if (errors <= 10)
        $display("table row mismatch: seg %0d,%0d,%0d,%0d table %p predictor %p",
                 a, b, c, d, want, p);
    end
    pending_clips.push_back(p);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(reg_sel_t r, int unsigned v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_BITS'(r) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic shortint near(longint lim);
    return shortint'(longint'($urandom_range(int'(2 * lim + 40))) - lim / 2 - 20);
  endfunction

  task automatic random_segment;
    shortint a, b, c, d;
    clip_t none;
    a = shortint'($urandom);
    b = shortint'($urandom);
    c = shortint'($urandom);
    d = shortint'($urandom);
    case ($urandom_range(9))
      0: ;
      1: begin
        a = near(win_w); c = a; b = near(win_h); d = near(win_h);
      end
      2: begin
        b = near(win_h); d = b; a = near(win_w); c = near(win_w);
      end
      3: begin
        a = near(win_w); b = near(win_h); c = a; d = b;
      end
      4: begin
        a = near(win_w); b = near(win_h);
      end
      default: begin
        a = near(win_w); b = near(win_h); c = near(win_w); d = near(win_h);
      end
    endcase
    send_segment(a, b, c, d, 0, none);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= calm || $urandom_range(99) >= 30;
    end
  end

  always @(posedge clk) begin
    clip_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_clips.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %b %h", m_tuser, m_tdata);
      end else begin
        want = pending_clips.pop_front();
        if (m_tuser !== want.visible || m_tdata[15:0] !== want.sx ||
            m_tdata[31:16] !== want.sy || m_tdata[47:32] !== want.ex ||
            m_tdata[63:48] !== want.ey) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want vis %b %h %h %h %h got vis %b %h %h %h %h",
                     want.visible, want.sx, want.sy, want.ex, want.ey, m_tuser,
                     m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic clip_t c(bit v, shortint a, shortint b, shortint e, shortint d);
    clip_t r;
    r.visible = v; r.sx = a; r.sy = b; r.ex = e; r.ey = d;
    return r;
  endfunction

  seg_row_t table_rows[$];
  int unsigned widths[6]  = '{1, 8192, 0, 0, 300, 16383};
  int unsigned heights[6] = '{1, 8192, 0, 5, 200, 16383};

  initial begin
    clip_t z;
    z = c(0, 0, 0, 0, 0);
    table_rows = '{
      '{10, 20, 100, 200, 1, c(1, 10, 20, 100, 200)},
      '{5, 300, 5, -10, 1, c(1, 5, 0, 5, 300)},
      '{-1, 10, -1, 20, 1, z},
      '{640, 10, 640, 20, 1, z},
      '{7, 500, 7, 600, 1, c(1, 7, 500, 7, 480)},
      '{700, 100, -20, 100, 1, c(1, 0, 100, 640, 100)},
      '{10, 480, 20, 480, 1, z},
      '{10, -1, 20, -1, 1, z},
      '{3, 3, 3, 3, 1, c(1, 3, 3, 3, 3)},
      '{-32768, -32768, -32768, -32768, 1, z},
      '{700, 0, 800, 10, 1, z},
      '{-10, 0, -5, 10, 1, z},
      '{0, -5, 10, -1, 1, z},
      '{0, 480, 10, 500, 1, z},
      '{-32768, -32768, 32767, 32767, 0, z},
      '{32767, 32767, -32768, -32768, 0, z},
      '{32767, -32768, -32768, 32767, 0, z},
      '{-100, -100, 1, 1000, 0, z},
      '{-50, 240, 900, 100, 0, z},
      '{320, -300, 330, 900, 0, z},
      '{639, 0, 0, 479, 0, z},
      '{-1, 479, 640, 0, 0, z}
    };
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (table_rows[i])
      send_segment(table_rows[i].sx, table_rows[i].sy, table_rows[i].ex,
                   table_rows[i].ey, table_rows[i].known, table_rows[i].want);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) begin
        widths[ph] = $urandom_range(8192, 1);
        heights[ph] = $urandom_range(8192, 1);
      end
      write_reg(REG_WIDTH, widths[ph]);
      write_reg(REG_HEIGHT, heights[ph]);
      win_w = widths[ph] & 16'h3fff;
      win_h = heights[ph] & 16'h3fff;
      for (int n = 0; n < 210; n++) begin
        calm = (ph == 1 && n < 120);
        if (ph == 3 && n == 40) stall_left = 400;
        if (ph == 2 && n == 100) begin
          s_tvalid <= 0;
          while (pending_clips.size() != 0) @(posedge clk);
        end
        random_segment();
      end
      calm = 0;
      drain();
    end
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule
